/* src/sha512_pkg.sv */
// Shared types, constants and round functions for the SHA-512 hasher.
// No dependencies; the hasher, front end, core and checker import this package.
package sha512_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUTQ_DEPTH  = 8;
    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;

    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  byte_count;
        logic        final_item;
    } t_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_result;

    // Classified request handed from the front end to the compression engine.
    typedef struct packed {
        logic [63:0] word;       // masked, 0x80 byte already merged when it fits
        logic [6:0]  bits_add;   // message bits this request adds (0..64)
        logic        final_op;   // last request of the message
        logic        pad_next;   // final word was full: 0x80 goes into a word of its own
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_core_state;

    localparam logic [63:0] IV_TABLE [0:HASH_WORDS-1] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] K_TABLE [0:ROUNDS-1] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] big_sigma0(input logic [63:0] x);
        return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic logic [63:0] big_sigma1(input logic [63:0] x);
        return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic logic [63:0] small_sigma0(input logic [63:0] x);
        return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sigma1(input logic [63:0] x);
        return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
    endfunction

endpackage

/* src/sha512_hasher.sv */
// Top level of the SHA-512 hasher: front end, request queue, engine, result queue.
// Depends on sha512_pkg, sha512_front, sha512_fifo and sha512_core.
// Each 128-byte block takes 16 word writes, 80 rounds and one update; the
// compression loop runs one round per cycle. Final item: padding words plus one
// or two compressions, then eight digest words, one per cycle while the result
// queue has room. Sync active-low reset empties both queues.
module sha512_hasher #(
    parameter int QueueDepth = sha512_pkg::QUEUE_DEPTH,
    parameter int OutqDepth  = sha512_pkg::OUTQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha512_pkg::t_item   i_item,
    input  logic                push,
    output logic                full,
    output sha512_pkg::t_result o_result,
    output logic                empty,
    input  logic                pop
);
    import sha512_pkg::*;

    t_op     front_op;
    t_op     queued_op;
    logic    op_empty;
    logic    op_pop;
    t_result core_res;
    logic    res_push;
    logic    res_full;

    // Classify the request: mask the final word and place the 0x80 marker.
    sha512_front u_front (
        .i_item (i_item),
        .o_op   (front_op)
    );

    // Hold classified requests so the input side keeps taking items during rounds.
    sha512_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (QueueDepth)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .o_full  (full),
        .i_pop   (op_pop),
        .o_data  (queued_op),
        .o_empty (op_empty)
    );

    // Buffer words, pad, compress, and emit the digest; reset loads the initial hash.
    sha512_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (queued_op),
        .i_op_valid (!op_empty),
        .o_op_pop   (op_pop),
        .o_res      (core_res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    // Hold digest words until the consumer takes them.
    sha512_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OutqDepth)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (core_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

/* src/sha512_front.sv */
// Front end: classifies an incoming item into a compression request.
// Depends on sha512_pkg (t_item, t_op, PAD_WORD).
module sha512_front (
    input  sha512_pkg::t_item i_item,
    output sha512_pkg::t_op   o_op
);
    import sha512_pkg::*;

    logic [3:0]  sat_bytes;
    logic [5:0]  shift;
    logic [63:0] keep_mask;

    always_comb begin
        // Saturate the byte count of a final word at eight.
        sat_bytes = (i_item.byte_count > 4'd8) ? 4'd8 : i_item.byte_count;
        shift     = {sat_bytes[2:0], 3'b000};
        keep_mask = ~({64{1'b1}} >> shift);
        if (sat_bytes[3]) begin
            keep_mask = {64{1'b1}};
        end

        o_op.final_op = i_item.final_item;
        if (!i_item.final_item) begin
            o_op.word     = i_item.message_word;
            o_op.bits_add = 7'd64;
            o_op.pad_next = 1'b0;
        end else if (sat_bytes[3]) begin
            o_op.word     = i_item.message_word;
            o_op.bits_add = 7'd64;
            o_op.pad_next = 1'b1;
        end else begin
            // Drop unused low bytes, merge the 0x80 marker right behind the data.
            o_op.word     = (i_item.message_word & keep_mask) | (PAD_WORD >> shift);
            o_op.bits_add = {sat_bytes, 3'b000};
            o_op.pad_next = 1'b0;
        end
    end

endmodule

/* src/sha512_fifo.sv */
// Small first-word-fall-through queue built from registers.
// Used between front end and engine and on the result side; no package needed.
module sha512_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/sha512_core.sv */
// Compression engine: block buffer, padding sequencer, 80-round loop, digest emit.
// Depends on sha512_pkg (t_op, t_result, t_core_state, tables and sigma functions).
module sha512_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha512_pkg::t_op     i_op,
    input  logic                i_op_valid,
    output logic                o_op_pop,
    output sha512_pkg::t_result o_res,
    output logic                o_res_push,
    input  logic                i_res_full
);
    import sha512_pkg::*;

    t_core_state r_state;
    t_core_state n_state;

    logic [63:0] r_h [0:HASH_WORDS-1];
    logic [63:0] r_v [0:HASH_WORDS-1];
    logic [63:0] r_w [0:BLOCK_WORDS-1];
    logic [3:0]  r_count;
    logic [63:0] r_bits;
    logic [6:0]  r_round;
    logic        r_final;
    logic        r_pad_pending;
    logic        r_len_ok;
    logic        r_done;
    logic [2:0]  r_out_idx;

    logic        wr_en;
    logic [63:0] wr_data;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] w_next;
    logic        emit_go;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    if (r_count == 4'd15) begin
                        n_state = ST_ROUND;
                    end else if (i_op.final_op) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_count == 4'd15) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == 7'(ROUNDS - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                priority if (r_done) begin
                    n_state = ST_EMIT;
                end else if (r_final) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!i_res_full && r_out_idx == 3'd7) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: buffer writes, request pop, result push.
    always_comb begin
        wr_en      = 1'b0;
        wr_data    = '0;
        o_op_pop   = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_op_pop = i_op_valid;
                wr_en    = i_op_valid;
                wr_data  = i_op.word;
            end
            ST_PAD: begin
                wr_en = 1'b1;
                priority if (r_pad_pending) begin
                    wr_data = PAD_WORD;
                end else if (r_count == 4'd15 && r_len_ok) begin
                    wr_data = r_bits;
                end else begin
                    wr_data = '0;
                end
            end
            ST_EMIT: o_res_push = !i_res_full;
            default: ;
        endcase
    end

    assign emit_go = (r_state == ST_EMIT) && !i_res_full;

    assign o_res.digest_word = r_h[r_out_idx];
    assign o_res.word_index  = r_out_idx;
    assign o_res.last_word   = (r_out_idx == 3'd7);

    // One round and one message schedule step.
    always_comb begin
        t1 = r_v[7] + big_sigma1(r_v[4]) + (r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6])))
           + K_TABLE[r_round] + r_w[0];
        t2 = big_sigma0(r_v[0]) + ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
        w_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    // Block buffer and working variables.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_w[r_count] <= wr_data;
        end
        if (r_state == ST_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= w_next;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (wr_en && r_count == 4'd15) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_v[i] <= r_h[i];
            end
        end
    end

    // Control state and chaining words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_h[i] <= IV_TABLE[i];
            end
            r_count       <= '0;
            r_bits        <= '0;
            r_round       <= '0;
            r_final       <= 1'b0;
            r_pad_pending <= 1'b0;
            r_len_ok      <= 1'b0;
            r_done        <= 1'b0;
            r_out_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (o_op_pop) begin
                r_bits <= r_bits + 64'(i_op.bits_add);
                if (i_op.final_op) begin
                    r_final       <= 1'b1;
                    r_pad_pending <= i_op.pad_next;
                    if (!i_op.pad_next) begin
                        r_len_ok <= (r_count != 4'd14);
                    end
                end
            end
            if (r_state == ST_PAD) begin
                if (r_pad_pending) begin
                    r_pad_pending <= 1'b0;
                    r_len_ok      <= (r_count != 4'd14);
                end else if (r_count == 4'd15 && r_len_ok) begin
                    r_done <= 1'b1;
                end
            end
            if (r_state == ST_ROUND) begin
                r_round <= (r_round == 7'(ROUNDS - 1)) ? '0 : r_round + 1'b1;
            end
            if (r_state == ST_UPDATE) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
                if (r_final) begin
                    r_len_ok <= 1'b1;
                end
            end
            if (emit_go) begin
                r_out_idx <= r_out_idx + 1'b1;
                if (r_out_idx == 3'd7) begin
                    // Digest out: return to the initial hash state.
                    for (int i = 0; i < HASH_WORDS; i++) begin
                        r_h[i] <= IV_TABLE[i];
                    end
                    r_bits   <= '0;
                    r_final  <= 1'b0;
                    r_done   <= 1'b0;
                    r_len_ok <= 1'b0;
                end
            end
        end
    end

endmodule

/* src/sha512_checker.sv */
// Port-level checks on the result side of the SHA-512 hasher, bound to its top level.
// Depends on sha512_pkg (t_result) and the sha512_hasher port list.
module sha512_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input sha512_pkg::t_result o_result,
    input logic                empty,
    input logic                pop
);
    import sha512_pkg::*;

    logic [2:0] r_exp_idx;

    // Track the digest position the next result should carry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (pop && !empty) begin
            r_exp_idx <= r_exp_idx + 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.word_index == r_exp_idx))
        else $error("digest words out of order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.last_word == (o_result.word_index == 3'd7)))
        else $error("last word flag disagrees with word index");

endmodule

bind sha512_hasher sha512_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_result (o_result),
    .empty    (empty),
    .pop      (pop)
);
